// File: rtl/cec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_pkg
// Shared types and codes for the coincidence event counter.
// ----------------------------------------------------------------------------
package cec_pkg;

    localparam int SLICE_W = 4;
    localparam int DET_W   = 3 * SLICE_W;
    localparam int NUM_CLASS  = 9;
    localparam int NUM_SINGLE = 4;
    localparam int OUT_W   = 32;

    typedef logic [1:0] t_action;
    typedef logic [3:0] t_sel;
    typedef logic [3:0] t_class;
    typedef logic [1:0] t_hits;

    localparam t_action ACT_COUNT = 2'd0;
    localparam t_action ACT_READ  = 2'd1;
    localparam t_action ACT_CLEAR = 2'd2;

    localparam t_sel SEL_UU  = 4'd0;
    localparam t_sel SEL_UO  = 4'd1;
    localparam t_sel SEL_UE  = 4'd2;
    localparam t_sel SEL_OU  = 4'd3;
    localparam t_sel SEL_EU  = 4'd6;
    localparam t_sel SEL_ACC = 4'd9;
    localparam t_sel SEL_AO  = 4'd10;
    localparam t_sel SEL_BE  = 4'd13;

    localparam t_class CLS_NONE       = 4'd0;
    localparam t_class CLS_ACCIDENTAL = 4'd9;

    // single counter slots
    localparam int SGL_AO = 0;
    localparam int SGL_AE = 1;
    localparam int SGL_BO = 2;
    localparam int SGL_BE = 3;

    typedef struct packed {
        t_action action;
        t_sel    sel;
        logic    accidental;
        t_class  cls;
        t_hits   n_ao;
        t_hits   n_ae;
        t_hits   n_bo;
        t_hits   n_be;
    } t_cmd;

endpackage

// File: rtl/cec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_front
// Classify an incoming word into a counter command.
// ----------------------------------------------------------------------------
module cec_front
    import cec_pkg::*;
(
    input  t_action             i_action,
    input  logic [DET_W-1:0]    i_detections,
    input  logic [SLICE_W-1:0]  i_noise_hits,
    input  t_sel                i_sel,
    output t_cmd                o_cmd
);

    logic [DET_W-1:0]   det;
    logic [SLICE_W-1:0] st;
    t_hits              n_bo, n_be, n_ao, n_ae;
    logic               acc;
    logic [1:0]         a_code, b_code;

    always_comb begin
        det  = i_detections | {i_noise_hits, {(2 * SLICE_W){1'b0}}};
        n_bo = 2'(det[0]) + 2'(det[4]) + 2'(det[8]);
        n_be = 2'(det[1]) + 2'(det[5]) + 2'(det[9]);
        n_ao = 2'(det[2]) + 2'(det[6]) + 2'(det[10]);
        n_ae = 2'(det[3]) + 2'(det[7]) + 2'(det[11]);
        acc  = ((n_ao != 2'd0) && (n_ae != 2'd0)) || ((n_bo != 2'd0) && (n_be != 2'd0))
            || (n_ao > 2'd1) || (n_ae > 2'd1) || (n_bo > 2'd1) || (n_be > 2'd1);
        st     = det[3:0] | det[7:4] | det[11:8];
        a_code = st[3:2];
        b_code = st[1:0];

        o_cmd.action     = i_action;
        o_cmd.sel        = i_sel;
        o_cmd.accidental = acc;
        o_cmd.cls        = acc ? CLS_ACCIDENTAL
                         : t_class'({a_code, 1'b0}) + t_class'(a_code) + t_class'(b_code);
        o_cmd.n_ao       = n_ao;
        o_cmd.n_ae       = n_ae;
        o_cmd.n_bo       = n_bo;
        o_cmd.n_be       = n_be;
    end

endmodule

// File: rtl/cec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_queue
// Two-entry command queue between classifier and counter bank.
// ----------------------------------------------------------------------------
module cec_queue
    import cec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !do_pop) |=> (r_count == 2'd2))
        else $error("queue lost an entry");
`endif

endmodule

// File: rtl/cec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_back
// Counter bank: execute count, read and clear commands; register results.
// ----------------------------------------------------------------------------
module cec_back
    import cec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ignore,
    input  logic               i_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OUT_W-1:0]   o_value,
    output t_class             o_class
);

    logic [COUNT_WIDTH-1:0] r_class [NUM_CLASS];
    logic [COUNT_WIDTH-1:0] r_single [NUM_SINGLE];
    logic [COUNT_WIDTH-1:0] r_acc;
    logic                   r_valid;
    logic [OUT_W-1:0]       r_value;
    t_class                 r_cls;

    logic                   fire;
    logic [COUNT_WIDTH-1:0] base, addend, rd_sum;
    logic [63:0]            rd_ext;
    logic [OUT_W-1:0]       n_value;
    t_class                 n_cls;

    assign fire    = i_valid && (!r_valid || i_ready);
    assign o_pop   = fire;
    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_class = r_cls;

    always_comb begin
        base   = '0;
        addend = '0;
        if (i_cmd.sel < t_sel'(NUM_CLASS)) begin
            base = r_class[i_cmd.sel];
            if (i_ignore) begin
                if (i_cmd.sel == SEL_UU) begin
                    addend = r_acc;
                end
            end else begin
                if (i_cmd.sel == SEL_OU) begin
                    addend = r_single[SGL_AO];
                end else if (i_cmd.sel == SEL_EU) begin
                    addend = r_single[SGL_AE];
                end else if (i_cmd.sel == SEL_UO) begin
                    addend = r_single[SGL_BO];
                end else if (i_cmd.sel == SEL_UE) begin
                    addend = r_single[SGL_BE];
                end
            end
        end else if (i_cmd.sel == SEL_ACC) begin
            base = r_acc;
        end else if (i_cmd.sel >= SEL_AO && i_cmd.sel <= SEL_BE) begin
            base = r_single[i_cmd.sel[1:0] + 2'd2];
        end
        rd_sum = base + addend;
        rd_ext = 64'(rd_sum);

        n_value = '0;
        n_cls   = CLS_NONE;
        unique case (i_cmd.action)
            ACT_COUNT: n_cls   = i_cmd.cls;
            ACT_READ:  n_value = rd_ext[OUT_W-1:0];
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            for (int i = 0; i < NUM_CLASS; i++) begin
                r_class[i] <= '0;
            end
            for (int i = 0; i < NUM_SINGLE; i++) begin
                r_single[i] <= '0;
            end
        end else if (fire) begin
            unique case (i_cmd.action)
                ACT_COUNT: begin
                    if (i_cmd.accidental) begin
                        r_acc <= r_acc + COUNT_WIDTH'(1);
                        r_single[SGL_AO] <= r_single[SGL_AO] + COUNT_WIDTH'(i_cmd.n_ao);
                        r_single[SGL_AE] <= r_single[SGL_AE] + COUNT_WIDTH'(i_cmd.n_ae);
                        r_single[SGL_BO] <= r_single[SGL_BO] + COUNT_WIDTH'(i_cmd.n_bo);
                        r_single[SGL_BE] <= r_single[SGL_BE] + COUNT_WIDTH'(i_cmd.n_be);
                    end else begin
                        for (int i = 0; i < NUM_CLASS; i++) begin
                            if (i_cmd.cls == t_class'(i)) begin
                                r_class[i] <= r_class[i] + COUNT_WIDTH'(1);
                            end
                        end
                    end
                end
                ACT_CLEAR: begin
                    r_acc <= '0;
                    for (int i = 0; i < NUM_CLASS; i++) begin
                        r_class[i] <= '0;
                    end
                    for (int i = 0; i < NUM_SINGLE; i++) begin
                        r_single[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_value <= n_value;
            r_cls   <= n_cls;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cmd.action == ACT_CLEAR) |=> (r_acc == '0 && r_single[SGL_AO] == '0))
        else $error("clear left a counter set");
    a_acc_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cmd.action == ACT_COUNT && i_cmd.accidental)
        |=> (r_cls == CLS_ACCIDENTAL && r_acc == $past(r_acc) + COUNT_WIDTH'(1)))
        else $error("accidental word not counted");
    a_read_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cmd.action == ACT_READ) |=> (r_cls == CLS_NONE))
        else $error("read result carries a class");
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_cmd.action == ACT_COUNT && !i_cmd.accidental)
        |-> (i_cmd.cls < t_class'(NUM_CLASS)))
        else $error("class index out of range");
`endif

endmodule

// File: rtl/coincidence_event_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincidence_event_counter_top
// Coincidence classifier and counter bank for two polarizer stations.
// ----------------------------------------------------------------------------
// One word in and one word out per clock when the output side is ready. A
// word is classified on entry, waits in a two-entry queue, and is executed
// by the counter bank; that execute stage sets the rate of one word per
// cycle. A word passes the queue register and then the result register.
// Every word, including reads and clears, returns exactly one result word.
module coincidence_event_counter_top
    import cec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // ignore_accidentals
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // detections[11:0], noise_hits[15:12]
    input  logic [5:0]  i_s_axis_tuser,  // action[1:0], counter_select[5:2]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // count_value[31:0]
    output logic [3:0]  o_m_axis_tuser   // event_class[3:0]
);

    logic r_ignore;
    t_cmd front_cmd, queue_cmd;
    logic queue_ready, queue_valid, back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore <= 1'b0;
        end else if (i_cfg_we) begin
            r_ignore <= i_cfg_wdata;
        end
    end

    cec_front u_front (
        .i_action     (i_s_axis_tuser[1:0]),
        .i_detections (i_s_axis_tdata[11:0]),
        .i_noise_hits (i_s_axis_tdata[15:12]),
        .i_sel        (i_s_axis_tuser[5:2]),
        .o_cmd        (front_cmd)
    );

    cec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_cmd   (front_cmd),
        .o_ready (queue_ready),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    assign o_s_axis_tready = queue_ready;

    cec_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ignore(r_ignore),
        .i_valid (queue_valid),
        .i_cmd   (queue_cmd),
        .o_pop   (back_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (o_m_axis_tdata),
        .o_class (o_m_axis_tuser)
    );

endmodule
